[hw/rtl/mvm_pkg.sv]
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the integer matrix-vector multiply engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int DATA_W     = 32;
  localparam int ROW_IDX_W  = 6;
  localparam int COL_IDX_W  = 6;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_WR_MATRIX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_VECTOR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE   = 2'd2;

  // Register indexes, taken from paddr[2].
  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;

  localparam logic [CNT_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CNT_W-1:0] COLS_RESET = 7'd64;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] col_index;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]     out_row;
    logic signed [DATA_W-1:0] row_sum;
    logic                     last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

[hw/rtl/matrix_vector_multiply.sv]
// ---------------------------------------------------------------------------
// matrix_vector_multiply
// Integer matrix-vector multiply engine: load words fill the matrix and
// vector RAMs, a compute word streams one dot product per row in use.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in_      in         in_valid / in_stall    mvm_pkg::in_word_t
//   out_     out        out_valid / out_stall  mvm_pkg::out_word_t
//   cfg      in/out     APB psel/penable       rows_in_use @0x0, cols_in_use @0x4
//
// A load word is written as it is accepted and never raises in_stall. A compute
// word keeps in_stall high until the pipeline has emptied: rows * max(cols, 1)
// matrix RAM reads, one per cycle while the result register is free or being
// taken, then the stages drain; with no rows in use it raises no stall. A stalled
// result freezes the read/multiply/accumulate pipeline and extends the compute.
// Reset idles control and sets both counts to 64; RAMs hold garbage until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_multiply #(
  parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mvm_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mvm_pkg::out_word_t               out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mvm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mvm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = RAW + 1;
  localparam int CCW = CAW + 1;
  localparam int MDEPTH = MAX_ROWS * MAX_COLS;
  localparam int MAW = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int DW = mvm_pkg::DATA_W;

  // Configuration registers.
  logic [mvm_pkg::CNT_W-1:0] rows_cfg_r;
  logic [mvm_pkg::CNT_W-1:0] cols_cfg_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= mvm_pkg::ROWS_RESET;
      cols_cfg_r <= mvm_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == mvm_pkg::CFG_IDX_ROWS) begin
        rows_cfg_r <= pwdata[mvm_pkg::CNT_W-1:0];
      end else begin
        cols_cfg_r <= pwdata[mvm_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mvm_pkg::CFG_IDX_ROWS) begin
      prdata = mvm_pkg::CFG_DATA_W'(rows_cfg_r);
    end else begin
      prdata = mvm_pkg::CFG_DATA_W'(cols_cfg_r);
    end
  end

  // Counts clamped to the store dimensions.
  logic [RCW-1:0] nr_eff;
  logic [CCW-1:0] nc_eff;
  logic [CCW-1:0] nc_iss;
  logic           cols_nonzero;

  assign nr_eff = (32'(rows_cfg_r) >= 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_r);
  assign nc_eff = (32'(cols_cfg_r) >= 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_cfg_r);
  assign cols_nonzero = (nc_eff != '0);
  // With no columns each row still takes one slot, with its product forced to zero.
  assign nc_iss = cols_nonzero ? nc_eff : CCW'(1);

  // Control.
  mvm_pkg::state_t state_r, state_nxt;
  logic [RAW-1:0]  row_r, row_nxt;
  logic [CAW-1:0]  col_r, col_nxt;
  logic            adv;
  logic            issue;
  logic            last_col;
  logic            last_row;
  logic            in_acc;
  logic            start;

  logic            s1_vld_r, s1_first_r, s1_lastc_r, s1_lastr_r, s1_use_r;
  logic [RAW-1:0]  s1_row_r;
  logic            s2_vld_r, s2_first_r, s2_lastc_r, s2_lastr_r;
  logic [RAW-1:0]  s2_row_r;
  logic [DW-1:0]   prod_r;
  logic [DW-1:0]   acc_r;
  logic [DW-1:0]   acc_sum;
  logic            out_valid_r;
  mvm_pkg::out_word_t out_r;

  // The pipeline moves whenever the result register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign last_col = (({1'b0, col_r} + CCW'(1)) == nc_iss);
  assign last_row = (({1'b0, row_r} + RCW'(1)) == nr_eff);
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && (in_data.mode == mvm_pkg::MODE_COMPUTE) && (nr_eff != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mvm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = mvm_pkg::ST_RUN;
        end
      end
      mvm_pkg::ST_RUN: begin
        if (issue && last_row && last_col) begin
          state_nxt = mvm_pkg::ST_DRAIN;
        end
      end
      mvm_pkg::ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = mvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mvm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    case (state_r)
      mvm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      mvm_pkg::ST_RUN: begin
        issue = adv;
      end
      mvm_pkg::ST_DRAIN: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (start) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (issue) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RAW'(1);
      end else begin
        col_nxt = col_r + CAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  // Stores.
  logic          mat_we, vec_we;
  logic [MAW-1:0] mat_waddr, mat_raddr;
  logic [CAW-1:0] vec_waddr;
  logic [DW-1:0]  mat_rd, vec_rd;

  assign mat_we = in_acc && (in_data.mode == mvm_pkg::MODE_WR_MATRIX)
                  && (32'(in_data.row_index) < 32'(MAX_ROWS))
                  && (32'(in_data.col_index) < 32'(MAX_COLS));
  assign vec_we = in_acc && (in_data.mode == mvm_pkg::MODE_WR_VECTOR)
                  && (32'(in_data.col_index) < 32'(MAX_COLS));
  assign mat_waddr = MAW'(in_data.row_index) * MAW'(MAX_COLS) + MAW'(in_data.col_index);
  assign vec_waddr = CAW'(in_data.col_index);
  assign mat_raddr = MAW'(row_r) * MAW'(MAX_COLS) + MAW'(col_r);

  mvm_ram #(
    .WIDTH (DW),
    .DEPTH (MDEPTH),
    .AW    (MAW)
  ) u_matrix_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (in_data.value),
    .re    (issue),
    .raddr (mat_raddr),
    .rdata (mat_rd)
  );

  mvm_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_COLS),
    .AW    (CAW)
  ) u_vector_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (in_data.value),
    .re    (issue),
    .raddr (col_r),
    .rdata (vec_rd)
  );

  // Read, multiply and accumulate stages; all hold together when adv is low.
  logic [DW-1:0] prod_nxt;

  assign prod_nxt = mat_rd * vec_rd;
  assign acc_sum  = (s2_first_r ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= issue;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r && s2_lastc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= (col_r == '0);
      s1_lastc_r <= last_col;
      s1_lastr_r <= last_row;
      s1_use_r   <= cols_nonzero;
      s1_row_r   <= row_r;

      s2_first_r <= s1_first_r;
      s2_lastc_r <= s1_lastc_r;
      s2_lastr_r <= s1_lastr_r;
      s2_row_r   <= s1_row_r;
      prod_r     <= s1_use_r ? prod_nxt : '0;

      if (s2_vld_r) begin
        acc_r <= acc_sum;
      end
      if (s2_vld_r && s2_lastc_r) begin
        out_r.out_row <= mvm_pkg::ROW_IDX_W'(s2_row_r);
        out_r.row_sum <= acc_sum;
        out_r.last    <= s2_lastr_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/mvm_ram.sv]
// ---------------------------------------------------------------------------
// mvm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // Read data holds while re is low.
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
